FILE: rtl/intra_last_run_level_vlc_encoder_macros.svh
// Assertion helpers shared by the checking code of the encoder.
`ifndef INTRA_LAST_RUN_LEVEL_VLC_ENCODER_MACROS_SVH
`define INTRA_LAST_RUN_LEVEL_VLC_ENCODER_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define ILRL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define ILRL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ilrl_pkg.sv
// ----------------------------------------------------------------------------
// ilrl_pkg
// Types, table and constants of the advanced intra last-run-level VLC encoder.
// ----------------------------------------------------------------------------
package ilrl_pkg;

    localparam int TableSize  = 102;
    localparam int LastSplit  = 58;
    localparam int IdxW       = $clog2(TableSize);
    localparam logic [6:0] EscMarker = 7'b0000011;
    localparam logic [4:0] EscLength = 5'd22;

    typedef struct packed {
        logic              last_flag;
        logic [5:0]        zero_run;
        logic signed [7:0] coef_level;
    } t_in_beat;

    typedef struct packed {
        logic [21:0] codeword;
        logic [4:0]  code_length;
    } t_out_beat;

    // Per-stage handshake control: valid from upstream, load of this stage.
    typedef struct packed {
        logic valid;
        logic load;
    } t_stage_ctl;

    typedef struct packed {
        logic       last;
        logic [5:0] run;
        logic [7:0] level;
        logic [7:0] mag;
    } t_s1;

    typedef struct packed {
        logic                  last;
        logic [5:0]            run;
        logic [7:0]            level;
        logic [TableSize-1:0]  match;
    } t_s2;

    typedef struct packed {
        logic            last;
        logic [5:0]      run;
        logic [7:0]      level;
        logic            hit;
        logic [IdxW-1:0] idx;
    } t_s3;

    typedef struct packed {
        logic [4:0] run;
        logic [4:0] mag;
        logic [3:0] len;
        logic [6:0] code;
    } t_vlc_entry;

    // run, |level|, length without sign bit, code
    localparam t_vlc_entry VlcRom [TableSize] = '{
        '{5'd0, 5'd1, 4'd2, 7'h02},  '{5'd1, 5'd1, 4'd4, 7'h0F},
        '{5'd3, 5'd1, 4'd6, 7'h15},  '{5'd5, 5'd1, 4'd7, 7'h17},
        '{5'd7, 5'd1, 4'd8, 7'h1F},  '{5'd8, 5'd1, 4'd9, 7'h25},
        '{5'd9, 5'd1, 4'd9, 7'h24},  '{5'd10, 5'd1, 4'd10, 7'h21},
        '{5'd11, 5'd1, 4'd10, 7'h20}, '{5'd4, 5'd3, 4'd11, 7'h07},
        '{5'd9, 5'd2, 4'd11, 7'h06}, '{5'd13, 5'd1, 4'd11, 7'h20},
        '{5'd0, 5'd2, 4'd3, 7'h06},  '{5'd1, 5'd2, 4'd6, 7'h14},
        '{5'd1, 5'd4, 4'd8, 7'h1E},  '{5'd1, 5'd5, 4'd10, 7'h0F},
        '{5'd1, 5'd6, 4'd11, 7'h21}, '{5'd1, 5'd7, 4'd12, 7'h50},
        '{5'd0, 5'd3, 4'd4, 7'h0E},  '{5'd3, 5'd2, 4'd8, 7'h1D},
        '{5'd2, 5'd3, 4'd10, 7'h0E}, '{5'd3, 5'd4, 4'd12, 7'h51},
        '{5'd0, 5'd5, 4'd5, 7'h0D},  '{5'd4, 5'd2, 4'd9, 7'h23},
        '{5'd3, 5'd3, 4'd10, 7'h0D}, '{5'd0, 5'd4, 4'd5, 7'h0C},
        '{5'd5, 5'd2, 4'd9, 7'h22},  '{5'd5, 5'd3, 4'd12, 7'h52},
        '{5'd2, 5'd1, 4'd5, 7'h0B},  '{5'd6, 5'd2, 4'd10, 7'h0C},
        '{5'd0, 5'd25, 4'd12, 7'h53}, '{5'd4, 5'd1, 4'd6, 7'h13},
        '{5'd7, 5'd2, 4'd10, 7'h0B}, '{5'd0, 5'd24, 4'd12, 7'h54},
        '{5'd0, 5'd8, 4'd6, 7'h12},  '{5'd8, 5'd2, 4'd10, 7'h0A},
        '{5'd0, 5'd7, 4'd6, 7'h11},  '{5'd2, 5'd4, 4'd10, 7'h09},
        '{5'd0, 5'd6, 4'd6, 7'h10},  '{5'd12, 5'd1, 4'd10, 7'h08},
        '{5'd0, 5'd9, 4'd7, 7'h16},  '{5'd0, 5'd23, 4'd12, 7'h55},
        '{5'd2, 5'd2, 4'd7, 7'h15},  '{5'd1, 5'd3, 4'd7, 7'h14},
        '{5'd6, 5'd1, 4'd8, 7'h1C},  '{5'd0, 5'd10, 4'd8, 7'h1B},
        '{5'd0, 5'd12, 4'd9, 7'h21}, '{5'd0, 5'd11, 4'd9, 7'h20},
        '{5'd0, 5'd18, 4'd9, 7'h1F}, '{5'd0, 5'd17, 4'd9, 7'h1E},
        '{5'd0, 5'd16, 4'd9, 7'h1D}, '{5'd0, 5'd15, 4'd9, 7'h1C},
        '{5'd0, 5'd14, 4'd9, 7'h1B}, '{5'd0, 5'd13, 4'd9, 7'h1A},
        '{5'd0, 5'd20, 4'd11, 7'h22}, '{5'd0, 5'd19, 4'd11, 7'h23},
        '{5'd0, 5'd22, 4'd12, 7'h56}, '{5'd0, 5'd21, 4'd12, 7'h57},
        // last = 1
        '{5'd0, 5'd1, 4'd4, 7'h07},  '{5'd14, 5'd1, 4'd9, 7'h19},
        '{5'd20, 5'd1, 4'd11, 7'h05}, '{5'd1, 5'd1, 4'd6, 7'h0F},
        '{5'd19, 5'd1, 4'd11, 7'h04}, '{5'd2, 5'd1, 4'd6, 7'h0E},
        '{5'd3, 5'd1, 4'd6, 7'h0D},  '{5'd0, 5'd2, 4'd6, 7'h0C},
        '{5'd5, 5'd1, 4'd7, 7'h13},  '{5'd6, 5'd1, 4'd7, 7'h12},
        '{5'd4, 5'd1, 4'd7, 7'h11},  '{5'd0, 5'd3, 4'd7, 7'h10},
        '{5'd9, 5'd1, 4'd8, 7'h1A},  '{5'd10, 5'd1, 4'd8, 7'h19},
        '{5'd11, 5'd1, 4'd8, 7'h18}, '{5'd12, 5'd1, 4'd8, 7'h17},
        '{5'd13, 5'd1, 4'd8, 7'h16}, '{5'd8, 5'd1, 4'd8, 7'h15},
        '{5'd7, 5'd1, 4'd8, 7'h14},  '{5'd0, 5'd4, 4'd8, 7'h13},
        '{5'd17, 5'd1, 4'd9, 7'h18}, '{5'd18, 5'd1, 4'd9, 7'h17},
        '{5'd16, 5'd1, 4'd9, 7'h16}, '{5'd15, 5'd1, 4'd9, 7'h15},
        '{5'd2, 5'd2, 4'd9, 7'h14},  '{5'd1, 5'd2, 4'd9, 7'h13},
        '{5'd0, 5'd6, 4'd9, 7'h12},  '{5'd0, 5'd5, 4'd9, 7'h11},
        '{5'd4, 5'd2, 4'd10, 7'h07}, '{5'd3, 5'd2, 4'd10, 7'h06},
        '{5'd1, 5'd2, 4'd10, 7'h05}, '{5'd0, 5'd7, 4'd10, 7'h04},
        '{5'd2, 5'd3, 4'd11, 7'h24}, '{5'd1, 5'd4, 4'd11, 7'h25},
        '{5'd0, 5'd9, 4'd11, 7'h26}, '{5'd0, 5'd8, 4'd11, 7'h27},
        '{5'd21, 5'd1, 4'd12, 7'h58}, '{5'd22, 5'd1, 4'd12, 7'h59},
        '{5'd23, 5'd1, 4'd12, 7'h5A}, '{5'd7, 5'd2, 4'd12, 7'h5B},
        '{5'd6, 5'd2, 4'd12, 7'h5C}, '{5'd5, 5'd2, 4'd12, 7'h5D},
        '{5'd3, 5'd3, 4'd12, 7'h5E}, '{5'd0, 5'd10, 4'd12, 7'h5F}
    };

endpackage

FILE: rtl/intra_last_run_level_vlc_encoder.sv
// ----------------------------------------------------------------------------
// intra_last_run_level_vlc_encoder
// Advanced intra last-run-level VLC encoder, four register stages.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  (i_in_valid / o_in_ready / i_in_beat): one coefficient
//   event per beat - last flag, zero run and signed level.
//   Output channel (o_out_valid / i_out_ready / o_out_beat): one codeword
//   beat per input beat, right-aligned, with its length; length 22 is the
//   escape word.
//   Pipeline: input register, compare, priority select, output register.
//   Throughput: one beat per cycle unless the output stalls; every stage
//   is a plain register, the widest step being the 102-way compare
//   against the constant table.
//   Stall: while i_out_ready is low the output holds, and bubbles ahead of
//   it close up, so the input keeps taking beats until all four stages are
//   full. Nothing is dropped or repeated.
//   Reset: synchronous, active low; clears every stage valid bit. The
//   payload registers are not reset.
// ----------------------------------------------------------------------------
module intra_last_run_level_vlc_encoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ilrl_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ilrl_pkg::t_out_beat o_out_beat
);
    import ilrl_pkg::*;

    // stage 1: input register with the level magnitude
    logic r_v1;
    t_s1  r_s1;
    t_s1  n_s1;

    logic v2;
    logic v3;
    t_s2  s2;
    t_s3  s3;

    // load of each stage: empty, or its content moves on this cycle
    logic       load1;
    t_stage_ctl ctl2;
    t_stage_ctl ctl3;
    t_stage_ctl ctl4;

    assign ctl4.load  = !o_out_valid || i_out_ready;
    assign ctl4.valid = v3;
    assign ctl3.load  = !v3 || ctl4.load;
    assign ctl3.valid = v2;
    assign ctl2.load  = !v2 || ctl3.load;
    assign ctl2.valid = r_v1;
    assign load1      = !r_v1 || ctl2.load;

    assign o_in_ready = load1;

    // magnitude of the level; -128 gives 128 and so never matches
    always_comb begin
        n_s1.last  = i_in_beat.last_flag;
        n_s1.run   = i_in_beat.zero_run;
        n_s1.level = i_in_beat.coef_level;
        n_s1.mag   = i_in_beat.coef_level[7] ? (~i_in_beat.coef_level + 8'd1)
                                             : i_in_beat.coef_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (load1) begin
            r_v1 <= i_in_valid;
        end
    end

    // hold payload on stall, advance otherwise
    always_ff @(posedge i_clk) begin
        if (load1) begin
            r_s1 <= n_s1;
        end
    end

    ilrl_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl2),
        .i_s1    (r_s1),
        .o_valid (v2),
        .o_s2    (s2)
    );

    ilrl_select u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl3),
        .i_s2    (s2),
        .o_valid (v3),
        .o_s3    (s3)
    );

    ilrl_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl4),
        .i_s3    (s3),
        .o_valid (o_out_valid),
        .o_beat  (o_out_beat)
    );

endmodule

FILE: rtl/ilrl_match.sv
// ----------------------------------------------------------------------------
// ilrl_match
// Compare stage: one match bit for every table entry.
// ----------------------------------------------------------------------------
module ilrl_match (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ilrl_pkg::t_stage_ctl i_ctl,
    input  ilrl_pkg::t_s1       i_s1,
    output logic                o_valid,
    output ilrl_pkg::t_s2       o_s2
);
    import ilrl_pkg::*;

    logic r_valid;
    t_s2  r_s2;
    t_s2  n_s2;

    always_comb begin
        n_s2.last  = i_s1.last;
        n_s2.run   = i_s1.run;
        n_s2.level = i_s1.level;
        for (int i = 0; i < TableSize; i++) begin
            n_s2.match[i] = (i_s1.last == 1'(i >= LastSplit))
                          && (i_s1.run == {1'b0, VlcRom[i].run})
                          && (i_s1.mag == {3'b000, VlcRom[i].mag});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_valid;
    assign o_s2    = r_s2;

endmodule

FILE: rtl/ilrl_select.sv
// ----------------------------------------------------------------------------
// ilrl_select
// Priority stage: lowest matching entry wins.
// ----------------------------------------------------------------------------
module ilrl_select (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ilrl_pkg::t_stage_ctl i_ctl,
    input  ilrl_pkg::t_s2       i_s2,
    output logic                o_valid,
    output ilrl_pkg::t_s3       o_s3
);
    import ilrl_pkg::*;

    logic r_valid;
    t_s3  r_s3;
    t_s3  n_s3;

    always_comb begin
        n_s3.last  = i_s2.last;
        n_s3.run   = i_s2.run;
        n_s3.level = i_s2.level;
        n_s3.hit   = |i_s2.match;
        n_s3.idx   = '0;
        // scan downwards so the lowest set bit is left standing
        for (int i = TableSize - 1; i >= 0; i--) begin
            if (i_s2.match[i]) begin
                n_s3.idx = IdxW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_s3 <= n_s3;
        end
    end

    assign o_valid = r_valid;
    assign o_s3    = r_s3;

endmodule

FILE: rtl/ilrl_pack.sv
// ----------------------------------------------------------------------------
// ilrl_pack
// Output stage: table read and codeword assembly, escape on a miss.
// ----------------------------------------------------------------------------
module ilrl_pack (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ilrl_pkg::t_stage_ctl i_ctl,
    input  ilrl_pkg::t_s3       i_s3,
    output logic                o_valid,
    output ilrl_pkg::t_out_beat o_beat
);
    import ilrl_pkg::*;

    logic       r_valid;
    t_out_beat  r_beat;
    t_out_beat  n_beat;
    t_vlc_entry entry;

    always_comb begin
        entry = VlcRom[i_s3.idx];
        if (i_s3.hit) begin
            n_beat.codeword    = 22'({entry.code, i_s3.level[7]});
            n_beat.code_length = 5'(entry.len) + 5'd1;
        end else begin
            n_beat.codeword    = {EscMarker, i_s3.last, i_s3.run, i_s3.level};
            n_beat.code_length = EscLength;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

FILE: rtl/ilrl_checker.sv
// ----------------------------------------------------------------------------
// ilrl_checker
// Port-level checks of the encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "intra_last_run_level_vlc_encoder_macros.svh"

module ilrl_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input ilrl_pkg::t_out_beat o_out_beat
);
    import ilrl_pkg::*;

    logic in_beat_seen;
    assign in_beat_seen = i_in_valid && o_in_ready;

    `ILRL_ASSERT_NXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out_beat),
        "output beat dropped or changed while stalled")
    `ILRL_ASSERT_IMP(a_len_range, i_clk, i_rst_n,
        o_out_valid,
        (o_out_beat.code_length >= 5'd3) && (o_out_beat.code_length <= EscLength),
        "code length out of range")
    `ILRL_ASSERT_IMP(a_esc_marker, i_clk, i_rst_n,
        o_out_valid && (o_out_beat.code_length == EscLength),
        o_out_beat.codeword[21:15] == EscMarker,
        "escape word without marker")
    `ILRL_ASSERT_IMP(a_code_fits, i_clk, i_rst_n,
        o_out_valid && (o_out_beat.code_length != EscLength),
        (o_out_beat.codeword >> o_out_beat.code_length) == 22'd0,
        "table code wider than its length")
    `ILRL_ASSERT_NXT(a_latency, i_clk, i_rst_n,
        in_beat_seen && i_out_ready ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready,
        o_out_valid,
        "result missing three cycles after its input beat")

endmodule

bind intra_last_run_level_vlc_encoder ilrl_checker u_ilrl_checker (.*);
